>>> design/vector3_length_normalize_core_macros.svh
// ---------------------------------------------------------------------------
// vector3_length_normalize_core_macros.svh
// Assertion helpers for the vector length and normalize core
// ---------------------------------------------------------------------------
`ifndef VECTOR3_LENGTH_NORMALIZE_CORE_MACROS_SVH
`define VECTOR3_LENGTH_NORMALIZE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// implication or plain property checked on every clock outside reset
`define VLN_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define VLN_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define VLN_ASSERT_CLK(label, prop, msg)
`define VLN_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> design/vln_pkg.sv
// ---------------------------------------------------------------------------
// vln_pkg
// Widths, lane types and helpers shared by the vector normalize core
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vln_pkg;

    // field and arithmetic widths
    localparam int COORD_BITS     = 32;
    localparam int UNIT_FRAC_BITS = 30;
    localparam int IN_FIELD_W     = 32;
    localparam int SQ_W           = 2 * COORD_BITS;
    localparam int ROOT_W         = COORD_BITS;
    localparam int REM_W          = ROOT_W + 2;
    localparam int Q_W            = UNIT_FRAC_BITS + 1;
    localparam int DIV_LAT        = Q_W;
    localparam int PIPE_LAT       = 3 + ROOT_W + DIV_LAT;

    // output field widths
    localparam int LSQ_W          = 64;
    localparam int MAG_W          = 32;
    localparam int UNIT_W         = 32;
    localparam int IN_TDATA_W     = 3 * IN_FIELD_W;
    localparam int OUT_TDATA_W    = LSQ_W + MAG_W + 3 * UNIT_W;

    // values carried alongside the square root
    typedef struct packed {
        logic [SQ_W-1:0]       sq;
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] az;
        logic                  nx;
        logic                  ny;
        logic                  nz;
    } t_side;

    // one divider lane result
    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           neg;
    } t_lane_res;

    // signed unit component from quotient magnitude, zero for zero vector
    function automatic logic [UNIT_W-1:0] unit_word(input t_lane_res res, input logic zero);
        logic [UNIT_W-1:0] mag;
        mag = UNIT_W'(res.quo);
        if (zero) begin
            return '0;
        end
        return res.neg ? (~mag + UNIT_W'(1)) : mag;
    endfunction

endpackage

`default_nettype wire

>>> design/vln_square_lane.sv
// ---------------------------------------------------------------------------
// vln_square_lane
// Absolute value and square of one vector component, two register stages
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vln_square_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [vln_pkg::IN_FIELD_W-1:0]      i_comp,
    output logic      [vln_pkg::SQ_W-1:0]            o_sq,
    output logic      [vln_pkg::COORD_BITS-1:0]      o_abs,
    output logic                                     o_neg
);

    logic [vln_pkg::COORD_BITS-1:0] w_raw;
    logic [vln_pkg::COORD_BITS-1:0] w_abs;
    logic                           w_neg;
    logic [vln_pkg::COORD_BITS-1:0] r_abs;
    logic                           r_neg;
    logic [vln_pkg::SQ_W-1:0]       r_sq;
    logic [vln_pkg::COORD_BITS-1:0] r_abs2;
    logic                           r_neg2;

    // two's complement magnitude of the low coordinate bits
    always_comb begin
        w_raw = i_comp[vln_pkg::COORD_BITS-1:0];
        w_neg = w_raw[vln_pkg::COORD_BITS-1];
        w_abs = w_neg ? (~w_raw + vln_pkg::COORD_BITS'(1)) : w_raw;
    end

    // stage one: magnitude, stage two: square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs  <= w_abs;
            r_neg  <= w_neg;
            r_sq   <= vln_pkg::SQ_W'(r_abs) * vln_pkg::SQ_W'(r_abs);
            r_abs2 <= r_abs;
            r_neg2 <= r_neg;
        end
    end

    assign o_sq  = r_sq;
    assign o_abs = r_abs2;
    assign o_neg = r_neg2;

endmodule

`default_nettype wire

>>> design/vln_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// vln_sqrt_pipe
// Pipelined floor square root, one root bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vln_sqrt_pipe (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire vln_pkg::t_side              i_side,
    output vln_pkg::t_side                   o_side,
    output logic      [vln_pkg::ROOT_W-1:0]  o_root
);

    logic [vln_pkg::REM_W-1:0]  p_rem  [vln_pkg::ROOT_W];
    logic [vln_pkg::ROOT_W-1:0] p_root [vln_pkg::ROOT_W];
    vln_pkg::t_side             p_side [vln_pkg::ROOT_W];
    logic [vln_pkg::REM_W-1:0]  r_rem  [vln_pkg::ROOT_W];
    logic [vln_pkg::ROOT_W-1:0] r_root [vln_pkg::ROOT_W];
    vln_pkg::t_side             r_side [vln_pkg::ROOT_W];

    for (genvar k = 0; k < vln_pkg::ROOT_W; k++) begin : g_stage
        logic [vln_pkg::REM_W-1:0]  w_shift;
        logic [vln_pkg::REM_W-1:0]  w_trial;
        logic                       w_ge;
        logic [vln_pkg::REM_W-1:0]  n_rem;
        logic [vln_pkg::ROOT_W-1:0] n_root;

        // stage inputs: zero state at the head, previous stage otherwise
        if (k == 0) begin : g_head
            assign p_rem[k]  = '0;
            assign p_root[k] = '0;
            assign p_side[k] = i_side;
        end else begin : g_body
            assign p_rem[k]  = r_rem[k-1];
            assign p_root[k] = r_root[k-1];
            assign p_side[k] = r_side[k-1];
        end

        // bring down two radicand bits and try the next root bit
        always_comb begin
            w_shift = {p_rem[k][vln_pkg::REM_W-3:0],
                       p_side[k].sq[2*(vln_pkg::ROOT_W-1-k) +: 2]};
            w_trial = {p_root[k], 2'b01};
            w_ge    = (w_shift >= w_trial);
            n_rem   = w_ge ? (w_shift - w_trial) : w_shift;
            n_root  = {p_root[k][vln_pkg::ROOT_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= p_side[k];
            end
        end
    end

    assign o_root = r_root[vln_pkg::ROOT_W-1];
    assign o_side = r_side[vln_pkg::ROOT_W-1];

endmodule

`default_nettype wire

>>> design/vln_div_lane.sv
// ---------------------------------------------------------------------------
// vln_div_lane
// Pipelined restoring divider for one component, one quotient bit per stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vln_div_lane (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [vln_pkg::ROOT_W-1:0]      i_len,
    input  wire logic [vln_pkg::COORD_BITS-1:0]  i_abs,
    input  wire logic                            i_neg,
    output vln_pkg::t_lane_res                   o_res
);

    logic [vln_pkg::ROOT_W-1:0] r_rem [vln_pkg::DIV_LAT];
    logic [vln_pkg::Q_W-1:0]    r_quo [vln_pkg::DIV_LAT];
    logic [vln_pkg::ROOT_W-1:0] r_len [vln_pkg::DIV_LAT];
    logic                       r_neg [vln_pkg::DIV_LAT];

    for (genvar j = 0; j < vln_pkg::DIV_LAT; j++) begin : g_stage
        logic [vln_pkg::ROOT_W:0]   w_shift;
        logic [vln_pkg::ROOT_W:0]   w_diff;
        logic                       w_ge;
        logic [vln_pkg::ROOT_W-1:0] n_rem;
        logic [vln_pkg::Q_W-1:0]    n_quo;
        logic [vln_pkg::ROOT_W-1:0] w_len;
        logic                       w_neg;

        if (j == 0) begin : g_head
            // integer quotient bit: component against length
            always_comb begin
                w_len   = i_len;
                w_neg   = i_neg;
                w_shift = {1'b0, vln_pkg::ROOT_W'(i_abs)};
                w_diff  = w_shift - {1'b0, w_len};
                w_ge    = (w_shift >= {1'b0, w_len});
                n_rem   = w_ge ? w_diff[vln_pkg::ROOT_W-1:0] : w_shift[vln_pkg::ROOT_W-1:0];
                n_quo   = vln_pkg::Q_W'(w_ge);
            end
        end else begin : g_body
            // fraction bit: doubled remainder against length
            always_comb begin
                w_len   = r_len[j-1];
                w_neg   = r_neg[j-1];
                w_shift = {r_rem[j-1], 1'b0};
                w_diff  = w_shift - {1'b0, w_len};
                w_ge    = (w_shift >= {1'b0, w_len});
                n_rem   = w_ge ? w_diff[vln_pkg::ROOT_W-1:0] : w_shift[vln_pkg::ROOT_W-1:0];
                n_quo   = {r_quo[j-1][vln_pkg::Q_W-2:0], w_ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_quo[j] <= n_quo;
                r_len[j] <= w_len;
                r_neg[j] <= w_neg;
            end
        end
    end

    assign o_res.quo = r_quo[vln_pkg::DIV_LAT-1];
    assign o_res.neg = r_neg[vln_pkg::DIV_LAT-1];

endmodule

`default_nettype wire

>>> design/vln_merge.sv
// ---------------------------------------------------------------------------
// vln_merge
// Combines the lane quotients into one result item, output register and skid
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vln_merge (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_vld,
    input  wire logic [vln_pkg::SQ_W-1:0]          i_sq,
    input  wire logic [vln_pkg::ROOT_W-1:0]        i_len,
    input  wire vln_pkg::t_lane_res                i_res_x,
    input  wire vln_pkg::t_lane_res                i_res_y,
    input  wire vln_pkg::t_lane_res                i_res_z,
    input  wire logic                              i_m_tready,
    output logic                                   o_en,
    output logic                                   o_m_tvalid,
    output logic      [vln_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic      [0:0]                        o_m_tuser
);

    logic                              w_zero;
    logic [vln_pkg::OUT_TDATA_W-1:0]   w_data;
    logic                              w_take;
    logic                              w_load_out;
    logic                              w_load_skid;
    logic                              w_out_from_skid;
    logic                              r_ov;
    logic                              n_ov;
    logic                              r_sv;
    logic                              n_sv;
    logic [vln_pkg::OUT_TDATA_W-1:0]   r_out_data;
    logic                              r_out_zero;
    logic [vln_pkg::OUT_TDATA_W-1:0]   r_skid_data;
    logic                              r_skid_zero;

    // assemble the result item
    always_comb begin
        w_zero = (i_sq == '0);
        w_data = {vln_pkg::unit_word(i_res_z, w_zero),
                  vln_pkg::unit_word(i_res_y, w_zero),
                  vln_pkg::unit_word(i_res_x, w_zero),
                  vln_pkg::MAG_W'(i_len),
                  vln_pkg::LSQ_W'(i_sq)};
    end

    // output register and skid control
    always_comb begin
        w_take          = r_ov & i_m_tready;
        n_ov            = r_ov;
        n_sv            = r_sv;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (r_sv) begin
            if (w_take) begin
                w_out_from_skid = 1'b1;
                n_sv            = 1'b0;
            end
        end else if (i_vld) begin
            if (!r_ov || w_take) begin
                w_load_out = 1'b1;
                n_ov       = 1'b1;
            end else begin
                w_load_skid = 1'b1;
                n_sv        = 1'b1;
            end
        end else if (w_take) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out_data <= r_skid_data;
            r_out_zero <= r_skid_zero;
        end else if (w_load_out) begin
            r_out_data <= w_data;
            r_out_zero <= w_zero;
        end
        if (w_load_skid) begin
            r_skid_data <= w_data;
            r_skid_zero <= w_zero;
        end
    end

    assign o_en         = !r_sv;
    assign o_m_tvalid   = r_ov;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_zero;

endmodule

`default_nettype wire

>>> design/vector3_length_normalize_core.sv
// ---------------------------------------------------------------------------
// vector3_length_normalize_core
// Squared length, length, unit vector and zero flag of a Q16.16 3D vector
// ---------------------------------------------------------------------------
// Input stream: one vector item per handshake on i_s_tvalid / o_s_tready.
// Output stream: one result item per input item, in order, on o_m_tvalid /
// i_m_tready; o_m_tuser carries the zero-vector flag.
// From the accepting edge to the edge that raises o_m_tvalid, an item passes
// the first squaring register, which loads at the accepting edge, then the
// second squaring stage, the sum register, the square root pipeline with its
// root bit stages, the three divider lanes with their quotient bit stages
// (UNIT_FRAC_BITS + 1 quotient bits), and the output register. Throughput is
// one item per cycle while o_s_tready is high: every stage is a fully
// pipelined step.
// When the receiver stalls, the output register holds its item and the next
// finished item lands in a skid register; only once the skid is full does
// o_s_tready drop and the whole pipeline freeze, so no item is lost.
// Reset clears the valid bits of the pipeline and the output stage; no
// clearing pass is needed and an item may be sent in the first cycle after.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "vector3_length_normalize_core_macros.svh"

module vector3_length_normalize_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // comp_x [31:0], comp_y [63:32], comp_z [95:64]
    input  wire logic [vln_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // length_squared [63:0], magnitude [95:64], unit_x [127:96],
    // unit_y [159:128], unit_z [191:160]
    output logic      [vln_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // zero_vector [0]
    output logic      [0:0]                        o_m_tuser
);

    logic                           w_en;
    logic [vln_pkg::PIPE_LAT-1:0]   r_vld;
    logic [vln_pkg::SQ_W-1:0]       w_sq_x;
    logic [vln_pkg::SQ_W-1:0]       w_sq_y;
    logic [vln_pkg::SQ_W-1:0]       w_sq_z;
    logic [vln_pkg::COORD_BITS-1:0] w_abs_x;
    logic [vln_pkg::COORD_BITS-1:0] w_abs_y;
    logic [vln_pkg::COORD_BITS-1:0] w_abs_z;
    logic                           w_neg_x;
    logic                           w_neg_y;
    logic                           w_neg_z;
    vln_pkg::t_side                 r_side;
    vln_pkg::t_side                 w_root_side;
    logic [vln_pkg::ROOT_W-1:0]     w_root;
    logic [vln_pkg::SQ_W-1:0]       r_dsq  [vln_pkg::DIV_LAT];
    logic [vln_pkg::ROOT_W-1:0]     r_dlen [vln_pkg::DIV_LAT];
    vln_pkg::t_lane_res             w_res_x;
    vln_pkg::t_lane_res             w_res_y;
    vln_pkg::t_lane_res             w_res_z;

    assign o_s_tready = w_en;

    // valid bits follow the items through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[vln_pkg::PIPE_LAT-2:0], i_s_tvalid};
        end
    end

    // squaring lanes
    vln_square_lane u_sq_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_comp (i_s_tdata[0 +: vln_pkg::IN_FIELD_W]),
        .o_sq   (w_sq_x),
        .o_abs  (w_abs_x),
        .o_neg  (w_neg_x)
    );

    vln_square_lane u_sq_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_comp (i_s_tdata[vln_pkg::IN_FIELD_W +: vln_pkg::IN_FIELD_W]),
        .o_sq   (w_sq_y),
        .o_abs  (w_abs_y),
        .o_neg  (w_neg_y)
    );

    vln_square_lane u_sq_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_comp (i_s_tdata[2*vln_pkg::IN_FIELD_W +: vln_pkg::IN_FIELD_W]),
        .o_sq   (w_sq_z),
        .o_abs  (w_abs_z),
        .o_neg  (w_neg_z)
    );

    // sum of squares with the component magnitudes alongside
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side.sq <= w_sq_x + w_sq_y + w_sq_z;
            r_side.ax <= w_abs_x;
            r_side.ay <= w_abs_y;
            r_side.az <= w_abs_z;
            r_side.nx <= w_neg_x;
            r_side.ny <= w_neg_y;
            r_side.nz <= w_neg_z;
        end
    end

    vln_sqrt_pipe u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_side (r_side),
        .o_side (w_root_side),
        .o_root (w_root)
    );

    // squared length and length ride beside the divider lanes
    for (genvar j = 0; j < vln_pkg::DIV_LAT; j++) begin : g_dly
        if (j == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dsq[j]  <= w_root_side.sq;
                    r_dlen[j] <= w_root;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_dsq[j]  <= r_dsq[j-1];
                    r_dlen[j] <= r_dlen[j-1];
                end
            end
        end
    end

    // divider lanes
    vln_div_lane u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_len (w_root),
        .i_abs (w_root_side.ax),
        .i_neg (w_root_side.nx),
        .o_res (w_res_x)
    );

    vln_div_lane u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_len (w_root),
        .i_abs (w_root_side.ay),
        .i_neg (w_root_side.ny),
        .o_res (w_res_y)
    );

    vln_div_lane u_div_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_len (w_root),
        .i_abs (w_root_side.az),
        .i_neg (w_root_side.nz),
        .o_res (w_res_z)
    );

    // merge lanes and drive the output stream
    vln_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld[vln_pkg::PIPE_LAT-1]),
        .i_sq       (r_dsq[vln_pkg::DIV_LAT-1]),
        .i_len      (r_dlen[vln_pkg::DIV_LAT-1]),
        .i_res_x    (w_res_x),
        .i_res_y    (w_res_y),
        .i_res_z    (w_res_z),
        .i_m_tready (i_m_tready),
        .o_en       (w_en),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // a frozen pipeline keeps its items in place
    `VLN_ASSERT_CLK(a_freeze_holds, i_rst_n && !w_en |=> $stable(r_vld), "pipeline moved while frozen")
    // zero flag comes with zero length fields
    `VLN_ASSERT_CLK(a_zero_len, o_m_tvalid && o_m_tuser[0] |-> o_m_tdata[95:0] == '0, "zero item has length")
    // nonzero vector has nonzero magnitude
    `VLN_ASSERT_NEVER(a_mag_nonzero, o_m_tvalid && !o_m_tuser[0] && o_m_tdata[95:64] == '0, "zero magnitude")

endmodule

`default_nettype wire
